// ----- design/ssd_pkg.sv -----
// Shared constants, command codes and the character font for the display serializer.
`default_nettype none

package ssd_pkg;

  // Number of digit positions in the chain (1 to 8)
  localparam int unsigned POSITIONS  = 6;
  localparam int unsigned SEG_W      = 8;
  localparam int unsigned FRAME_BITS = POSITIONS * SEG_W;
  localparam int unsigned SLOT_W     = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
  localparam int unsigned CNT_W      = $clog2(FRAME_BITS);
  localparam int unsigned POS_W      = 4;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned CMD_W      = 3;

  localparam logic [SEG_W-1:0]  DOT_BIT     = 8'h20;
  localparam logic [CHAR_W-1:0] DOT_CHAR    = 8'h2E;
  localparam logic [POS_W-1:0]  STR_POS_MAX = 4'd15;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET_CHAR = 3'd0,
    CMD_OR_RAW   = 3'd1,
    CMD_CLEAR    = 3'd2,
    CMD_FILL     = 3'd3,
    CMD_STRING   = 3'd4,
    CMD_DISPLAY  = 3'd5
  } cmd_e;

  typedef logic [SLOT_W-1:0] slot_t;

  // Position 0 or beyond the chain lands on the first digit
  function automatic slot_t slot_of(input logic [POS_W-1:0] pos);
    slot_t s;
    if (pos == '0 || 32'(pos) > POSITIONS) begin
      s = '0;
    end else begin
      s = SLOT_W'(pos - 4'd1);
    end
    return s;
  endfunction

  // Font lookup, case-insensitive; unknown characters are blank
  function automatic logic [SEG_W-1:0] glyph_of(input logic [CHAR_W-1:0] ch);
    logic [CHAR_W-1:0] c;
    logic [SEG_W-1:0]  g;
    c = ch;
    if (ch inside {["a":"z"]}) begin
      c = ch - 8'd32;
    end
    case (c)
      "0": g = 8'hDD;
      "1": g = 8'h90;
      "2": g = 8'hC7;
      "3": g = 8'hD3;
      "4": g = 8'h9A;
      "5": g = 8'h5B;
      "6": g = 8'h5F;
      "7": g = 8'hD0;
      "8": g = 8'hDF;
      "9": g = 8'hDB;
      "A": g = 8'hDE;
      "B": g = 8'h1F;
      "C": g = 8'h07;
      "D": g = 8'h97;
      "E": g = 8'h4F;
      "F": g = 8'h4E;
      "H": g = 8'h1E;
      "R": g = 8'h06;
      "L": g = 8'h0D;
      "O": g = 8'h17;
      "Q": g = 8'h37;
      "P": g = 8'hCE;
      "T": g = 8'h0F;
      "U": g = 8'h15;
      "N": g = 8'h16;
      "-": g = 8'h02;
      "_": g = 8'h01;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// ----- design/ssd_if.sv -----
// Request and bit-stream channel interfaces of the display serializer.
`default_nettype none

interface ssd_in_if
  import ssd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [CHAR_W-1:0] character;
  logic [POS_W-1:0]  position;
  logic              dot;
  logic [SEG_W-1:0]  raw_segments;
  logic              string_start;

  modport source (
    output valid, cmd, character, position, dot, raw_segments, string_start,
    input  ready
  );
  modport sink (
    input  valid, cmd, character, position, dot, raw_segments, string_start,
    output ready
  );
endinterface

interface ssd_out_if;
  logic valid;
  logic ready;
  logic serial_data;
  logic latch;
  logic last;

  modport source (output valid, serial_data, latch, last, input ready);
  modport sink   (input valid, serial_data, latch, last, output ready);
endinterface

`default_nettype wire

// ----- design/ssd_shifter.sv -----
// Bit-serial output stage: shifts a captured display frame out MSB first.
`default_nettype none

module ssd_shifter
  import ssd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  load_i,
  input  wire logic [FRAME_BITS-1:0] frame_i,
  output      logic                  busy_o,
  ssd_out_if.source                  out_o
);

  logic                  valid_q, valid_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [FRAME_BITS-1:0] sh_q, sh_d;
  logic                  final_bit;
  logic                  bit_taken;

  assign final_bit = (cnt_q == CNT_W'(FRAME_BITS - 1));
  assign bit_taken = valid_q && out_o.ready;

  // Next-state: load a frame, then step one bit per taken output
  always_comb begin
    valid_d = valid_q;
    cnt_d   = cnt_q;
    sh_d    = sh_q;
    if (load_i) begin
      valid_d = 1'b1;
      cnt_d   = '0;
      sh_d    = frame_i;
    end else if (bit_taken) begin
      sh_d  = {sh_q[FRAME_BITS-2:0], 1'b0};
      cnt_d = cnt_q + CNT_W'(1);
      if (final_bit) begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
    end
  end

  // Frame data needs no reset
  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
  end

  // Data pin is active low
  assign out_o.valid       = valid_q;
  assign out_o.serial_data = ~sh_q[FRAME_BITS-1];
  assign out_o.latch       = final_bit;
  assign out_o.last        = final_bit;
  assign busy_o            = valid_q;

endmodule

`default_nettype wire

// ----- design/seven_segment_display_serializer_core.sv -----
// Top level of the seven-segment display serializer: digit store and command decode.
// Display streams POSITIONS * 8 bits (48 at six digits) one per cycle while the sink is
// ready, through the output shift register, then the block is ready again; the other
// commands only update the digit store.
// The request channel is held off while a frame is shifting; commands
// issued before a display are always reflected in it. Bits go out from the highest digit
// down, MSB first, inverted, and the final bit carries latch and last.
`default_nettype none

module seven_segment_display_serializer_core
  import ssd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ssd_in_if.sink    in_i,
  ssd_out_if.source out_o
);

  logic [SEG_W-1:0]      store_q [POSITIONS];
  logic [SEG_W-1:0]      store_d [POSITIONS];
  logic [POS_W-1:0]      str_pos_q, str_pos_d;
  logic                  prev_char_q, prev_char_d;
  logic                  busy;
  logic                  req_acc;
  logic                  load;
  logic [FRAME_BITS-1:0] frame;
  slot_t                 req_slot;
  logic [SEG_W-1:0]      req_glyph;
  logic [POS_W-1:0]      sp;
  logic [POS_W-1:0]      sp_next;
  logic                  pc;

  assign in_i.ready = !busy;
  assign req_acc    = in_i.valid && in_i.ready;
  assign req_slot   = slot_of(in_i.position);
  assign req_glyph  = glyph_of(in_i.character);

  // String position after an optional restart
  assign sp      = in_i.string_start ? '0 : str_pos_q;
  assign pc      = in_i.string_start ? 1'b0 : prev_char_q;
  assign sp_next = (sp < STR_POS_MAX) ? sp + POS_W'(1) : sp;

  // Command decode
  always_comb begin
    store_d     = store_q;
    str_pos_d   = str_pos_q;
    prev_char_d = prev_char_q;
    load        = 1'b0;
    if (req_acc) begin
      case (cmd_e'(in_i.cmd))
        CMD_SET_CHAR: begin
          store_d[req_slot] = req_glyph | (in_i.dot ? DOT_BIT : '0);
        end
        CMD_OR_RAW: begin
          store_d[req_slot] = store_q[req_slot] | in_i.raw_segments;
        end
        CMD_CLEAR: begin
          for (int k = 0; k < POSITIONS; k++) begin
            store_d[k] = '0;
          end
        end
        CMD_FILL: begin
          for (int k = 0; k < POSITIONS; k++) begin
            if (store_q[k] == '0) begin
              store_d[k] = req_glyph;
            end
          end
        end
        CMD_STRING: begin
          if (in_i.character == DOT_CHAR) begin
            // Dot attaches to the previous character, if any
            if (pc) begin
              store_d[slot_of(sp)] = store_q[slot_of(sp)] | DOT_BIT;
            end
            str_pos_d   = sp;
            prev_char_d = 1'b0;
          end else begin
            store_d[slot_of(sp_next)] = req_glyph;
            str_pos_d   = sp_next;
            prev_char_d = 1'b1;
          end
        end
        CMD_DISPLAY: begin
          load = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < POSITIONS; k++) begin
        store_q[k] <= '0;
      end
      str_pos_q   <= '0;
      prev_char_q <= 1'b0;
    end else begin
      store_q     <= store_d;
      str_pos_q   <= str_pos_d;
      prev_char_q <= prev_char_d;
    end
  end

  // Frame: highest digit in the top byte
  always_comb begin
    for (int p = 0; p < POSITIONS; p++) begin
      frame[p*SEG_W +: SEG_W] = store_q[p];
    end
  end

  ssd_shifter u_shifter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .frame_i (frame),
    .busy_o  (busy),
    .out_o   (out_o)
  );

`ifndef SYNTH
  // No request is taken while a frame is shifting
  a_no_req_while_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready)
    else $error("request channel open during shift");

  // A display request starts the bit stream in the next cycle
  a_display_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && in_i.cmd == CMD_DISPLAY) |=> (out_o.valid && !out_o.last))
    else $error("display did not start a frame");

  // Stream ends right after the last bit is taken
  a_stream_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.last) |=> !out_o.valid)
    else $error("stream continued past last bit");

  // Latch and last mark the same bit
  a_latch_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.latch == out_o.last))
    else $error("latch and last disagree");
`endif

endmodule

`default_nettype wire

// ----- dv/tb_seven_segment_display_serializer_core.sv -----
// Testbench for the seven-segment display serializer: directed and random requests checked bit by bit.
`timescale 1ns / 1ps

module tb_seven_segment_display_serializer_core
  import ssd_pkg::*;
;

  // Command codes the block must ignore
  localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

  // Font: characters and their segment bytes, first entry in the top byte
  localparam int unsigned GLYPH_COUNT = 28;
  localparam logic [GLYPH_COUNT*8-1:0] GLYPH_CODES = "0123456789ABCDEFHRLOQPTUN-_ ";
  localparam logic [GLYPH_COUNT*8-1:0] GLYPH_SEGS = {
    8'hDD, 8'h90, 8'hC7, 8'hD3, 8'h9A, 8'h5B, 8'h5F, 8'hD0, 8'hDF, 8'hDB,
    8'hDE, 8'h1F, 8'h07, 8'h97, 8'h4F, 8'h4E, 8'h1E, 8'h06, 8'h0D, 8'h17,
    8'h37, 8'hCE, 8'h0F, 8'h15, 8'h16, 8'h02, 8'h01, 8'h00
  };

  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned DRAIN_LIMIT  = 50000;
  localparam int unsigned TAIL_CYCLES  = 2 * FRAME_BITS;
  localparam int unsigned RANDOM_ITEMS = 60;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] character;
    logic [POS_W-1:0]  position;
    logic              dot;
    logic [SEG_W-1:0]  raw_segments;
    logic              string_start;
  } req_t;

  typedef struct packed {
    logic serial_data;
    logic latch;
    logic last;
  } frame_bit_t;

  logic clk_i;
  logic rst_ni;

  ssd_in_if  req_if ();
  ssd_out_if bit_if ();

  seven_segment_display_serializer_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (bit_if)
  );

  // Predicted display contents and string state
  logic [SEG_W-1:0] digits [POSITIONS];
  logic [POS_W-1:0] str_pos;
  logic             after_char;
  frame_bit_t       frame_bits_q [$];

  int unsigned mismatches;
  int unsigned bits_seen;
  int unsigned sent_reqs;

  // Idling knobs
  int unsigned max_gap;
  int unsigned burst_left;
  int unsigned stall_pct;
  bit          use_pattern;
  int unsigned hold_request;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  function automatic logic [SEG_W-1:0] glyph(input logic [CHAR_W-1:0] ch);
    logic [CHAR_W-1:0] up;
    logic [SEG_W-1:0]  segs;
    up   = (ch inside {["a":"z"]}) ? ch - 8'd32 : ch;
    segs = '0;
    for (int k = 0; k < GLYPH_COUNT; k++) begin
      if (GLYPH_CODES[8*(GLYPH_COUNT-1-k) +: 8] == up) begin
        segs = GLYPH_SEGS[8*(GLYPH_COUNT-1-k) +: 8];
      end
    end
    return segs;
  endfunction

  // Out-of-range positions fold onto the first digit
  function automatic int pick_slot(input logic [POS_W-1:0] pos);
    return (pos == '0 || pos > POSITIONS) ? 0 : int'(pos) - 1;
  endfunction

  function automatic void apply_request(input req_t r);
    frame_bit_t fb;
    case (r.cmd)
      CMD_SET_CHAR: digits[pick_slot(r.position)] = glyph(r.character) | (r.dot ? DOT_BIT : '0);
      CMD_OR_RAW:   digits[pick_slot(r.position)] |= r.raw_segments;
      CMD_CLEAR: begin
        for (int p = 0; p < POSITIONS; p++) digits[p] = '0;
      end
      CMD_FILL: begin
        for (int p = 0; p < POSITIONS; p++) begin
          if (digits[p] == '0) digits[p] = glyph(r.character);
        end
      end
      CMD_STRING: begin
        if (r.string_start) begin
          str_pos    = '0;
          after_char = 1'b0;
        end
        // a dot only marks the previous character
        if (r.character == DOT_CHAR) begin
          if (after_char) digits[pick_slot(str_pos)] |= DOT_BIT;
          after_char = 1'b0;
        end else begin
          if (str_pos < STR_POS_MAX) str_pos++;
          digits[pick_slot(str_pos)] = glyph(r.character);
          after_char = 1'b1;
        end
      end
      CMD_DISPLAY: begin
        // highest digit first, MSB first, inverted
        for (int p = POSITIONS - 1; p >= 0; p--) begin
          for (int b = SEG_W - 1; b >= 0; b--) begin
            fb.serial_data = ~digits[p][b];
            fb.latch       = (p == 0 && b == 0);
            fb.last        = (p == 0 && b == 0);
            frame_bits_q.push_back(fb);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic req_t rand_req();
    req_t r;
    r.cmd          = CMD_W'($urandom_range(7));
    r.character    = CHAR_W'($urandom);
    r.position     = POS_W'($urandom);
    r.dot          = 1'($urandom);
    r.raw_segments = SEG_W'($urandom);
    r.string_start = 1'($urandom);
    return r;
  endfunction

  function automatic req_t mk_req(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                                  input logic [POS_W-1:0] pos, input logic dot,
                                  input logic [SEG_W-1:0] raw, input logic start);
    req_t r;
    r.cmd          = cmd;
    r.character    = ch;
    r.position     = pos;
    r.dot          = dot;
    r.raw_segments = raw;
    r.string_start = start;
    return r;
  endfunction

  // Mostly font characters, either case, plus dots and arbitrary bytes
  function automatic logic [CHAR_W-1:0] rand_char();
    logic [CHAR_W-1:0] ch;
    ch = GLYPH_CODES[8*$urandom_range(GLYPH_COUNT - 1) +: 8];
    case ($urandom_range(5))
      0:       ch = CHAR_W'($urandom);
      1:       ch = DOT_CHAR;
      2:       ch = (ch inside {["A":"Z"]}) ? ch + 8'd32 : ch;
      default: ;
    endcase
    return ch;
  endfunction

  // Caller sits at a falling edge; returns at the falling edge after acceptance
  task automatic send_req(input req_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap        = (max_gap == 0) ? 0 : $urandom_range(max_gap);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    req_if.valid        <= 1'b1;
    req_if.cmd          <= r.cmd;
    req_if.character    <= r.character;
    req_if.position     <= r.position;
    req_if.dot          <= r.dot;
    req_if.raw_segments <= r.raw_segments;
    req_if.string_start <= r.string_start;
    do @(posedge clk_i); while (!req_if.ready);
    apply_request(r);
    sent_reqs++;
    @(negedge clk_i);
  endtask

  task automatic send_display();
    req_t r;
    r     = rand_req();
    r.cmd = CMD_DISPLAY;
    send_req(r);
  endtask

  // Sender goes quiet until all predicted bits are out, or the limit runs out
  task automatic drain_frames(input int unsigned limit);
    int unsigned waited;
    waited       = 0;
    req_if.valid <= 1'b0;
    do begin
      @(negedge clk_i);
      waited++;
    end while (frame_bits_q.size() != 0 && waited < limit);
  endtask

  task automatic pick_idling();
    case ($urandom_range(3))
      0:       max_gap = 0;
      1:       max_gap = 2;
      2:       max_gap = 6;
      default: max_gap = 15;
    endcase
    case ($urandom_range(3))
      0:       stall_pct = 0;
      1:       stall_pct = 25;
      2:       stall_pct = 60;
      default: stall_pct = 85;
    endcase
    use_pattern = 1'($urandom);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_blank_frame();
    send_display();
  endtask

  task automatic test_set_and_raw();
    send_req(mk_req(CMD_SET_CHAR, "0", 4'd1, 1'b0, 8'h00, 1'b0));
    send_req(mk_req(CMD_SET_CHAR, "a", 4'd6, 1'b1, 8'hFF, 1'b1));
    send_req(mk_req(CMD_SET_CHAR, 8'hFF, 4'd0, 1'b1, 8'h00, 1'b0));
    send_req(mk_req(CMD_SET_CHAR, "q", 4'd15, 1'b0, 8'h00, 1'b0));
    send_req(mk_req(CMD_OR_RAW, 8'h00, 4'd3, 1'b0, 8'hFF, 1'b0));
    send_req(mk_req(CMD_OR_RAW, 8'hFF, 4'd2, 1'b1, 8'h00, 1'b1));
    send_req(mk_req(CMD_OR_RAW, 8'h00, 4'd7, 1'b0, 8'h80, 1'b0));
    send_display();
  endtask

  task automatic test_fill_clear();
    send_req(mk_req(CMD_FILL, "8", 4'd0, 1'b1, 8'h00, 1'b0));
    send_display();
    send_req(mk_req(CMD_CLEAR, 8'h00, 4'd0, 1'b0, 8'h00, 1'b0));
    send_req(mk_req(CMD_FILL, "z", 4'd0, 1'b0, 8'h00, 1'b0));
    send_req(mk_req(CMD_RSVD_6, "7", 4'd2, 1'b1, 8'hFF, 1'b1));
    send_req(mk_req(CMD_RSVD_7, "7", 4'd2, 1'b1, 8'hFF, 1'b1));
    send_display();
  endtask

  task automatic test_strings();
    send_req(mk_req(CMD_STRING, DOT_CHAR, 4'd0, 1'b0, 8'h00, 1'b1));
    send_req(mk_req(CMD_STRING, "H", 4'd0, 1'b0, 8'h00, 1'b0));
    send_req(mk_req(CMD_STRING, DOT_CHAR, 4'd0, 1'b0, 8'h00, 1'b0));
    send_req(mk_req(CMD_STRING, DOT_CHAR, 4'd0, 1'b0, 8'h00, 1'b0));
    send_req(mk_req(CMD_STRING, "i", 4'd0, 1'b0, 8'h00, 1'b0));
    send_req(mk_req(CMD_STRING, 8'h00, 4'd0, 1'b0, 8'h00, 1'b0));
    send_display();
  endtask

  // Sink holds off while requests keep coming, then the sender waits for every bit
  task automatic test_backpressure();
    req_t r;
    max_gap      = 0;
    stall_pct    = 0;
    use_pattern  = 1'b0;
    hold_request = LONG_HOLD;
    // a string long enough to saturate the position counter
    for (int k = 0; k < 18; k++) begin
      r = mk_req(CMD_STRING, GLYPH_CODES[8*(GLYPH_COUNT-1-k) +: 8], 4'd0, 1'b0, 8'h00, k == 0);
      send_req(r);
    end
    send_display();
    send_display();
    send_req(mk_req(CMD_SET_CHAR, "5", 4'd4, 1'b1, 8'h00, 1'b0));
    send_display();
    drain_frames(DRAIN_LIMIT);
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned len;
    req_t        r;
    stop_at = sent_reqs + n_items;
    while (sent_reqs < stop_at) begin
      pick_idling();
      case ($urandom_range(9))
        // positional writes then a refresh
        0, 1, 2: begin
          len = $urandom_range(1, 5);
          repeat (len) begin
            r = rand_req();
            if ($urandom_range(2) == 0) begin
              r.cmd = CMD_OR_RAW;
            end else begin
              r.cmd       = CMD_SET_CHAR;
              r.character = rand_char();
            end
            send_req(r);
          end
          send_display();
        end
        // a string, sometimes longer than the chain
        3, 4, 5: begin
          len = $urandom_range(1, 20);
          for (int k = 0; k < len; k++) begin
            r              = rand_req();
            r.cmd          = CMD_STRING;
            r.character    = rand_char();
            r.string_start = (k == 0) || ($urandom_range(15) == 0);
            send_req(r);
          end
          send_display();
        end
        // clear, a few writes, fill the rest
        6, 7: begin
          r     = rand_req();
          r.cmd = CMD_CLEAR;
          send_req(r);
          len = $urandom_range(0, 3);
          repeat (len) begin
            r           = rand_req();
            r.cmd       = CMD_SET_CHAR;
            r.character = rand_char();
            send_req(r);
          end
          r           = rand_req();
          r.cmd       = CMD_FILL;
          r.character = rand_char();
          send_req(r);
          send_display();
        end
        // noise
        default: begin
          len = $urandom_range(1, 4);
          repeat (len) send_req(rand_req());
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------- sink

  initial begin : sink_proc
    int unsigned hold_left;
    int unsigned phase;
    logic [15:0] pattern;
    hold_left    = 0;
    phase        = 0;
    pattern      = 16'b1101_0111_0110_1001;
    bit_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      phase = (phase + 1) % 16;
      if (hold_left != 0) begin
        bit_if.ready <= 1'b0;
        hold_left--;
      end else if (use_pattern) begin
        bit_if.ready <= pattern[phase];
      end else begin
        bit_if.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------- bit checker

  always @(posedge clk_i) begin
    frame_bit_t got;
    frame_bit_t want;
    if (rst_ni && bit_if.valid && bit_if.ready) begin
      got = '{bit_if.serial_data, bit_if.latch, bit_if.last};
      if (frame_bits_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected bit %0d: serial_data=%b latch=%b last=%b",
                   bits_seen, got.serial_data, got.latch, got.last);
        end
      end else begin
        want = frame_bits_q.pop_front();
        if (got.serial_data !== want.serial_data || got.latch !== want.latch ||
            got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("bit %0d: serial_data %b/%b latch %b/%b last %b/%b (expected/actual)",
                     bits_seen, want.serial_data, got.serial_data, want.latch, got.latch,
                     want.last, got.last);
          end
        end
      end
      bits_seen++;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_ni              = 1'b0;
    req_if.valid        = 1'b0;
    req_if.cmd          = '0;
    req_if.character    = '0;
    req_if.position     = '0;
    req_if.dot          = 1'b0;
    req_if.raw_segments = '0;
    req_if.string_start = 1'b0;
    for (int p = 0; p < POSITIONS; p++) digits[p] = '0;
    str_pos      = '0;
    after_char   = 1'b0;
    mismatches   = 0;
    bits_seen    = 0;
    sent_reqs    = 0;
    max_gap      = 0;
    burst_left   = 0;
    stall_pct    = 0;
    use_pattern  = 1'b0;
    hold_request = 0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_blank_frame();
    test_set_and_raw();
    max_gap   = 3;
    stall_pct = 40;
    test_fill_clear();
    use_pattern = 1'b1;
    test_strings();
    test_backpressure();
    test_random_traffic(RANDOM_ITEMS);

    stall_pct   = 0;
    use_pattern = 1'b0;
    drain_frames(DRAIN_LIMIT);
    if (frame_bits_q.size() != 0) begin
      mismatches += frame_bits_q.size();
      $display("%0d expected bits never arrived", frame_bits_q.size());
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("seven_segment_display_serializer_core: match");
    end else begin
      $display("seven_segment_display_serializer_core: mismatch");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("seven_segment_display_serializer_core: mismatch");
    $finish;
  end

endmodule

// ----- sim.f -----
design/ssd_pkg.sv
design/ssd_if.sv
design/ssd_shifter.sv
design/seven_segment_display_serializer_core.sv
dv/tb_seven_segment_display_serializer_core.sv
